[design/rsl_pkg.sv]
// Shared types, widths and constants for the radial spotlight luminance block.
package rsl_pkg;

  // Field widths
  localparam int COORD_BITS = 12;
  localparam int LUM_BITS   = 16;
  localparam int CTR_W      = COORD_BITS + 1;   // signed center register
  localparam int DIFF_W     = COORD_BITS + 2;   // signed pixel - center
  localparam int ABS_W      = COORD_BITS + 1;   // magnitude of the difference
  localparam int SQ_W       = 2 * ABS_W;
  localparam int SUM_W      = SQ_W + 1;

  // Spotlight geometry: radius 160 pixels, distance carried in Q.8
  localparam int NEAR_DIST  = 160;
  localparam int NEAR_SQ_I  = NEAR_DIST * NEAR_DIST;
  localparam int NEAR_W     = $clog2(NEAR_SQ_I);          // squared distance inside radius
  localparam logic [SUM_W-1:0] NEAR_SQ = SUM_W'(NEAR_SQ_I);
  localparam int DIST_FRAC  = 8;

  // Square root: radicand = squared distance << 16, root < 160*256
  localparam int ROOT_W      = 16;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STEPS  = 4;                          // root bits per stage
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // Falloff: floor(d8 * 32 / 25) as a reciprocal multiply
  localparam int DQ_W      = ROOT_W + 5;                   // d8 * 32
  localparam int RECIP_W   = 22;
  localparam int RECIP_SH  = 26;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(2684355); // ceil(2^26 / 25)
  localparam int PRODQ_W   = DQ_W + RECIP_W;
  localparam int Q_W       = 16;

  // Scale factor, Q1.16
  localparam int FACT_W = 17;
  localparam logic [FACT_W-1:0] UNITY      = FACT_W'(65536);
  localparam logic [FACT_W-1:0] FAR_FACTOR = FACT_W'(13107);  // floor(0.2 * 2^16)

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } cfg_reg_t;

  // Squared distance handed from the distance front end to the square root
  typedef struct packed {
    logic                far;
    logic [NEAR_W-1:0]   sum_near;
    logic [LUM_BITS-1:0] lum;
  } sq_item_t;

  // Distance handed from the square root to the scaler
  typedef struct packed {
    logic                far;
    logic [ROOT_W-1:0]   dist_q8;
    logic [LUM_BITS-1:0] lum;
  } dist_item_t;

  // Running state of the digit-by-digit square root
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_state_t;

  // One root bit: bring down two radicand bits, trial subtract
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    sqrt_state_t      r;
    rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial  = {s.root, 2'b01};
    r.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[design/radial_spotlight_luminance_top.sv]
// Pipeline: 10 register stages (3 distance, 4 root, 3 scale).
// Throughput: one pixel per cycle while out_stall is low; each stage advances when empty
// or when the next one moves, so bubbles are squeezed out and a stalled output holds its result.
// Reset (rst, synchronous): clears all stage valid bits and both center registers to 0.
// Center registers are written through cfg_we/cfg_index/cfg_data with no wait.
module radial_spotlight_luminance_top import rsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CTR_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [LUM_BITS-1:0]   lum_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LUM_BITS-1:0]   lum_out
);

  logic [CTR_W-1:0] center_x, center_y;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       sq_valid, sq_stall;
  sq_item_t   sq_item;
  logic       d_valid, d_stall;
  dist_item_t d_item;

  rsl_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .center_x  (center_x),
    .center_y  (center_y),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .lum_in    (lum_in),
    .out_valid (sq_valid),
    .out_stall (sq_stall),
    .out_item  (sq_item)
  );

  rsl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_stall  (sq_stall),
    .in_item   (sq_item),
    .out_valid (d_valid),
    .out_stall (d_stall),
    .out_item  (d_item)
  );

  rsl_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_stall  (d_stall),
    .in_item   (d_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lum_out   (lum_out)
  );

endmodule

[design/rsl_dist.sv]
// Front end: coordinate differences, squares and squared-distance sum (three stages).
module rsl_dist import rsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CTR_W-1:0]      center_x,
  input  logic [CTR_W-1:0]      center_y,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [LUM_BITS-1:0]   lum_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sq_item_t              out_item
);

  logic [2:0] v;
  logic [3:0] en;

  // Each stage loads when empty or when the next one moves
  assign en[3] = !out_stall;
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  // Stage 1: signed differences and magnitudes
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        dx_abs, dy_abs;
  logic [ABS_W-1:0]         ax, ay;
  logic [LUM_BITS-1:0]      lum1;

  always_comb begin
    dx = $signed({2'b00, pixel_x}) - $signed({center_x[CTR_W-1], center_x});
    dy = $signed({2'b00, pixel_y}) - $signed({center_y[CTR_W-1], center_y});
    dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax   <= dx_abs[ABS_W-1:0];
      ay   <= dy_abs[ABS_W-1:0];
      lum1 <= lum_in;
    end
  end

  // Stage 2: squares
  logic [SQ_W-1:0]     sqx, sqy;
  logic [LUM_BITS-1:0] lum2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx  <= ax * ax;
      sqy  <= ay * ay;
      lum2 <= lum1;
    end
  end

  // Stage 3: sum and radius test; beyond the radius the distance value is not needed
  logic [SUM_W-1:0] sum;
  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      out_item.far      <= (sum >= NEAR_SQ);
      out_item.sum_near <= sum[NEAR_W-1:0];
      out_item.lum      <= lum2;
    end
  end

  assign out_valid = v[2];

endmodule

[design/rsl_sqrt.sv]
// Pipelined integer square root, four root bits per stage, distance out in Q.8.
module rsl_sqrt import rsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  sq_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output dist_item_t out_item
);

  logic [SQRT_STAGES-1:0] v;
  logic [SQRT_STAGES:0]   en;
  sqrt_state_t            st   [SQRT_STAGES];
  logic                   far  [SQRT_STAGES];
  logic [LUM_BITS-1:0]    lum  [SQRT_STAGES];
  sqrt_state_t            st_in [SQRT_STAGES];
  logic                   far_in[SQRT_STAGES];
  logic [LUM_BITS-1:0]    lum_in[SQRT_STAGES];
  sqrt_state_t            seed;

  // Radicand = squared distance scaled by 2^16
  always_comb begin
    seed.rem  = '0;
    seed.root = '0;
    seed.rad  = {{(RAD_W - NEAR_W - 2 * DIST_FRAC){1'b0}}, in_item.sum_near,
                 {(2 * DIST_FRAC){1'b0}}};
  end

  assign en[SQRT_STAGES] = !out_stall;
  assign in_stall = !en[0];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    sqrt_state_t s_next;

    assign en[k] = !v[k] || en[k+1];

    if (k == 0) begin : g_first
      assign st_in[k]  = seed;
      assign far_in[k] = in_item.far;
      assign lum_in[k] = in_item.lum;
    end else begin : g_rest
      assign st_in[k]  = st[k-1];
      assign far_in[k] = far[k-1];
      assign lum_in[k] = lum[k-1];
    end

    // Four dependent root steps
    always_comb begin
      s_next = st_in[k];
      for (int i = 0; i < SQRT_STEPS; i++) begin
        s_next = sqrt_step(s_next);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= (k == 0) ? in_valid : v[k-1 < 0 ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k]  <= s_next;
        far[k] <= far_in[k];
        lum[k] <= lum_in[k];
      end
    end
  end

  assign out_valid        = v[SQRT_STAGES-1];
  assign out_item.far     = far[SQRT_STAGES-1];
  assign out_item.dist_q8 = st[SQRT_STAGES-1].root;
  assign out_item.lum     = lum[SQRT_STAGES-1];

endmodule

[design/rsl_scale.sv]
// Back end: falloff quotient, scale factor and luminance product (three stages).
module rsl_scale import rsl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dist_item_t          in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LUM_BITS-1:0] lum_out
);

  logic [2:0] v;
  logic [3:0] en;

  assign en[3] = !out_stall;
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  // Stage 1: floor(d8 * 32 / 25) by reciprocal multiply
  logic [PRODQ_W-1:0]  prod_q;
  logic [Q_W-1:0]      q;
  logic                far1;
  logic [LUM_BITS-1:0] lum1;

  assign prod_q = PRODQ_W'({in_item.dist_q8, 5'b00000}) * PRODQ_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q    <= prod_q[RECIP_SH +: Q_W];
      far1 <= in_item.far;
      lum1 <= in_item.lum;
    end
  end

  // Stage 2: Q1.16 factor, fixed 0.2 at or beyond the radius
  logic [FACT_W-1:0]   factor;
  logic [LUM_BITS-1:0] lum2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      factor <= far1 ? FAR_FACTOR : UNITY - FACT_W'(q);
      lum2   <= lum1;
    end
  end

  // Stage 3: truncated product, output register
  logic [LUM_BITS+FACT_W-1:0] prod_l;
  assign prod_l = (LUM_BITS+FACT_W)'(lum2) * (LUM_BITS+FACT_W)'(factor);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lum_out <= prod_l[16 +: LUM_BITS];
    end
  end

  assign out_valid = v[2];

endmodule

[design/rsl_checker.sv]
// Port-level assertions for the spotlight block, bound to the top level.
module rsl_checker import rsl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [LUM_BITS-1:0]   lum_out
);

  // A stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(lum_out))
    else $error("stalled result changed or dropped");

  // Input backs up only when every stage, the output one included, is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with room in the pipeline");

  // With the output side taking results, input is never stalled
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind radial_spotlight_luminance_top rsl_checker u_rsl_checker (.*);
